// ===== hw/rtl/twfa_pkg.sv =====
// Shared types and constants for the time window frame average unit.
// No dependencies.
package twfa_pkg;

    localparam int DATA_W         = 32;
    localparam int RING_DEPTH_DEF = 128;
    localparam int HELD_W         = 8;
    localparam logic [DATA_W-1:0] SPAN_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/time_window_frame_average_unit.sv =====
// Time window frame average: ring of recent frame durations, trimmed to a span.
// Each item passes through the add step, one trim read per entry dropped
// (at most RING_DEPTH-1), the serial divider and the output register.
// Throughput: one item at a time; the next item is taken once the result sits
// in the output register. Sync active-low reset clears control state and sets
// the span to 1000000; the ring memory is not cleared. Depends on twfa_pkg.
module time_window_frame_average_unit #(
    parameter int RING_DEPTH = twfa_pkg::RING_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: window_span
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] frame_duration
    input  logic [0:0]  s_tuser,   // [0] restart
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] average_duration, [39:32] entries_held,
                                   // [71:40] window_total
);
    import twfa_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int PW = CW + 1;
    localparam int HW = (CW > HELD_W) ? CW : HELD_W;
    localparam int TW = DATA_W + 1;

    state_t state_reg, state_next;

    logic [31:0]       span_reg;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [DATA_W-1:0] dur_reg, dur_next;

    // ring memory, one write and one registered read per cycle
    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              ring_we;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] avg_reg;
    logic [HELD_W-1:0] held_reg;
    logic [DATA_W-1:0] wtot_reg;
    logic              out_load;

    // divider
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quot;

    // add step helpers
    logic              full;
    logic [AW-1:0]     slot_add;
    logic [CW-1:0]     count_add;
    logic [PW-1:0]     diff_w;
    logic [AW-1:0]     oldest_add;
    logic [AW-1:0]     oldest_inc;
    logic              trim_go;
    logic [HW-1:0]     cnt_ext;
    logic [HELD_W-1:0] held_val;

    assign full      = (count_reg == CW'(RING_DEPTH));
    assign slot_add  = (slot_reg == AW'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign count_add = full ? count_reg : count_reg + 1'b1;
    // oldest = (slot_add - count_add) mod depth
    assign diff_w    = PW'(slot_add) + PW'(RING_DEPTH) - PW'(count_add);
    assign oldest_add = (diff_w >= PW'(RING_DEPTH)) ? AW'(diff_w - PW'(RING_DEPTH))
                                                    : AW'(diff_w);
    assign oldest_inc = (oldest_reg == AW'(RING_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    // keep dropping the oldest while over span and more than one entry held
    assign trim_go   = (total_reg > {1'b0, span_reg}) && (count_reg > CW'(1));

    // entries_held saturates at 255 for deep rings
    assign cnt_ext   = HW'(count_reg);
    assign held_val  = (cnt_ext > HW'(255)) ? HELD_W'(255) : cnt_ext[HELD_W-1:0];

    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        oldest_next = oldest_reg;
        dur_next    = dur_reg;
        rd_addr     = slot_reg;
        ring_we     = 1'b0;
        div_start   = 1'b0;
        out_load    = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dur_next = s_tdata;
                    // read the slot about to be overwritten, for eviction
                    if (s_tuser[0]) begin
                        slot_next  = '0;
                        count_next = '0;
                        total_next = '0;
                        rd_addr    = '0;
                    end
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                ring_we     = 1'b1;
                total_next  = total_reg - (full ? {1'b0, rd_data_reg} : '0)
                              + {1'b0, dur_reg};
                count_next  = count_add;
                slot_next   = slot_add;
                oldest_next = oldest_add;
                rd_addr     = oldest_add;
                state_next  = ST_TRIM;
            end
            ST_TRIM: begin
                rd_addr = oldest_inc;
                if (trim_go) begin
                    total_next  = total_reg - {1'b0, rd_data_reg};
                    count_next  = count_reg - 1'b1;
                    oldest_next = oldest_inc;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            span_reg    <= SPAN_RESET;
            slot_reg    <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                span_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        oldest_reg <= oldest_next;
        dur_reg    <= dur_next;
        if (out_load) begin
            avg_reg  <= div_quot;
            held_reg <= held_val;
            wtot_reg <= total_reg[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= dur_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    twfa_divider #(
        .CW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg[DATA_W-1:0]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {wtot_reg, held_reg, avg_reg};

endmodule

// ===== hw/rtl/twfa_divider.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on twfa_pkg.
module twfa_divider #(
    parameter int CW = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [twfa_pkg::DATA_W-1:0] dividend,
    input  logic [CW-1:0]             divisor,
    output logic                      done,
    output logic [twfa_pkg::DATA_W-1:0] quotient
);
    import twfa_pkg::*;

    localparam int IW = $clog2(DATA_W);

    logic [CW-1:0]     rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [IW-1:0]     iter_reg, iter_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW:0]       trial;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            iter_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? CW'(trial - {1'b0, divisor}) : CW'(trial);
            quo_next  = {quo_reg[DATA_W-2:0], ge};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == IW'(DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/twfa_checker.sv =====
// Port-level checks for the time window frame average unit, bound to the top.
// Depends on the top level's port list only.
module twfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [31:0] cfg_wr_data,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous still in work");

    // window always holds at least one entry
    a_held_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[39:32] != 8'd0)
        else $error("result with empty window");

    // floor average never exceeds total
    a_avg_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:0] <= m_tdata[71:40])
        else $error("average above window total");

endmodule

bind time_window_frame_average_unit twfa_checker u_twfa_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for time_window_frame_average_unit: a behavioral
// copy of the duration window predicts every result item on the stream bus.
// Depends on twfa_pkg and the unit's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import twfa_pkg::*;

    localparam int unsigned DEPTH         = RING_DEPTH_DEF;
    // settling wait long enough for the longest trim run and the divider
    localparam int unsigned SETTLE_CYCLES = 40 + DEPTH;
    localparam logic [31:0] SPAN_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0] DUR_MAX       = 32'hFFFF_FFFF;

    // laid out like m_tdata: first member lands in the top bits
    typedef struct packed {
        logic [31:0] window_total;
        logic [7:0]  entries_held;
        logic [31:0] average_duration;
    } frame_stats_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;   // [31:0] frame_duration
    logic [0:0]  s_tuser     = '0;   // [0] restart
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [71:0] m_tdata;            // [31:0] average, [39:32] held, [71:40] total

    // Predictor state: our own copy of the ring, its pointers and the span.
    logic [31:0]     duration_copy [DEPTH];
    int unsigned     next_slot;
    int unsigned     held_count;
    longint unsigned held_sum;
    logic [31:0]     span_setting;

    frame_stats_t    expected_stats_q [$];
    int unsigned     error_count;

    // Idle control: the gaps switch on and off per test, so some stretches run
    // at full rate. hold_left is a long receiver hold-off, counted down below.
    bit              idle_gaps_on;
    int unsigned     stall_left;
    int unsigned     hold_left;

    time_window_frame_average_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 90);
    endfunction

    // Add one duration to the window and trim it back under the span.
    function automatic frame_stats_t window_update(input logic [31:0] dur,
                                                   input logic restart_flag);
        frame_stats_t stats;
        int unsigned  oldest;
        if (restart_flag) begin
            next_slot  = 0;
            held_count = 0;
            held_sum   = 0;
        end
        // ring full: the entry about to be overwritten leaves the window
        if (held_count == DEPTH) begin
            held_sum   -= duration_copy[next_slot];
            held_count -= 1;
        end
        duration_copy[next_slot] = dur;
        next_slot   = (next_slot + 1) % DEPTH;
        held_count += 1;
        held_sum   += dur;
        // never trims below one entry, so a long frame stands alone
        while (held_sum > span_setting && held_count > 1) begin
            oldest      = (next_slot + DEPTH - held_count) % DEPTH;
            held_sum   -= duration_copy[oldest];
            held_count -= 1;
        end
        stats.average_duration = 32'(held_sum / held_count);
        stats.entries_held     = (held_count > 255) ? 8'd255 : 8'(held_count);
        stats.window_total     = 32'(held_sum);
        return stats;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // One frame item; returns at the edge where it is taken, tvalid still high.
    task automatic send_frame(input logic [31:0] dur, input logic restart_flag);
        int unsigned gap;
        gap = (idle_gaps_on && $urandom_range(0, 1)) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid   = 1'b1;
        s_tdata    = dur;
        s_tuser[0] = restart_flag;
        do @(posedge aclk); while (!s_tready);
        expected_stats_q.push_back(window_update(dur, restart_flag));
    endtask

    // Sender pauses until every result is back and the unit is idle again.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_stats_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_span(input logic [31:0] span);
        drain_results();
        cfg_wr_en    = 1'b1;
        cfg_wr_data  = span;
        span_setting = span;
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
    endtask

    // Reset span, long frames that overflow 32 bits before the trim, restarts,
    // alternating bit patterns.
    task automatic test_reset_span();
        idle_gaps_on = 1'b0;
        send_frame(32'd16666, 1'b0);
        send_frame(32'd16666, 1'b0);
        send_frame(32'd16667, 1'b0);
        send_frame(32'd0, 1'b0);
        send_frame(32'd1000000, 1'b0);
        send_frame(DUR_MAX, 1'b0);
        send_frame(DUR_MAX, 1'b0);
        send_frame(32'd33333, 1'b1);
        send_frame(32'hAAAA_AAAA, 1'b0);
        send_frame(32'h5555_5555, 1'b1);
        send_frame(32'd0, 1'b1);
        send_frame(32'd1, 1'b0);
    endtask

    // Span zero (keeps only the newest unless all are zero), span one, span max.
    task automatic test_span_extremes();
        write_span(32'd0);
        send_frame(32'd5, 1'b0);
        send_frame(32'd7, 1'b0);
        send_frame(32'd0, 1'b1);
        send_frame(32'd0, 1'b0);
        send_frame(32'd3, 1'b0);
        write_span(32'd1);
        send_frame(32'd1, 1'b0);
        send_frame(32'd0, 1'b0);
        send_frame(32'd1, 1'b0);
        send_frame(32'd2, 1'b0);
        write_span(SPAN_MAX);
        send_frame(32'h7FFF_FFFF, 1'b1);
        send_frame(32'h8000_0000, 1'b0);
        send_frame(DUR_MAX, 1'b0);
    endtask

    // Huge span so the random frames never trim: the ring fills, then evicts its oldest entry.
    task automatic test_ring_wrap();
        write_span(SPAN_MAX);
        idle_gaps_on = 1'b1;
        send_frame(32'd1000, 1'b1);
        for (int i = 1; i < 200; i++) begin
            // one max frame midway empties the window down to itself
            send_frame((i == 170) ? DUR_MAX : 32'($urandom_range(0, 33000000)), 1'b0);
        end
    endtask

    // Receiver holds off long enough for the unit to stall its input.
    task automatic test_output_backpressure();
        write_span(32'd100000);
        idle_gaps_on = 1'b0;
        @(posedge aclk);
        hold_left = 300;
        for (int i = 0; i < 16; i++) begin
            send_frame(32'($urandom_range(0, 40000)), 1'b0);
        end
    endtask

    // Phases of realistic frame times relative to the span, with some noise.
    task automatic test_random_windows();
        logic [31:0] span;
        logic [31:0] dur;
        int unsigned divisor;
        int unsigned r;
        for (int phase = 0; phase < 7; phase++) begin
            case (phase % 5)
                0: span = 32'($urandom_range(1, 2000));
                1: span = 32'd16666 * 32'($urandom_range(1, 130));
                2: span = SPAN_MAX;
                3: span = $urandom();
                default: span = 32'($urandom_range(100000, 5000000));
            endcase
            write_span(span);
            idle_gaps_on = (phase % 3 != 1);
            for (int i = 0; i < 100; i++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    dur = '0;
                end else if (r < 5) begin
                    dur = DUR_MAX;
                end else if (r < 12) begin
                    dur = $urandom();
                end else begin
                    divisor = $urandom_range(1, 160);
                    dur = span / divisor + 32'($urandom_range(0, span / (divisor * 8) + 1));
                end
                send_frame(dur, $urandom_range(0, 39) == 0);
            end
        end
    endtask

    // Receiver side: long hold-off first, then random stalls when enabled.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (idle_gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = pick_gap();
            end
        end
    end

    // Every taken result is held against the oldest prediction.
    always @(posedge aclk) begin
        frame_stats_t got;
        frame_stats_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_stats_q.size() == 0) begin
                report_mismatch("result with none expected, total", got.window_total, 0);
            end else begin
                want = expected_stats_q.pop_front();
                if (got.average_duration !== want.average_duration) begin
                    report_mismatch("average_duration", got.average_duration,
                                    want.average_duration);
                end
                if (got.entries_held !== want.entries_held) begin
                    report_mismatch("entries_held", got.entries_held, want.entries_held);
                end
                if (got.window_total !== want.window_total) begin
                    report_mismatch("window_total", got.window_total, want.window_total);
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        next_slot    = 0;
        held_count   = 0;
        held_sum     = 0;
        span_setting = SPAN_RESET;
        error_count  = 0;
        idle_gaps_on = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_span();
        test_span_extremes();
        test_ring_wrap();
        test_output_backpressure();
        test_random_windows();
        drain_results();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
